// ===== hw/rtl/xtea_pkg.sv =====
package xtea_pkg;

  localparam logic [31:0] DELTA       = 32'h9e37_79b9;
  localparam int          ROUNDS_DEF  = 32;
  localparam int          KEY_WORDS   = 4;
  localparam int          KEY_IDX_W   = 2;
  localparam int          ADDR_W      = 4;

  // Input transfer payload; also the item that travels down the round pipeline.
  typedef struct packed {
    logic        action;
    logic [31:0] block_low;
    logic [31:0] block_high;
  } in_t;

  typedef struct packed {
    logic [31:0] out_low;
    logic [31:0] out_high;
  } out_t;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  // Feistel mixing term ((v << 4) ^ (v >> 5)) + v
  function automatic logic [31:0] mix_word(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

// ===== hw/rtl/xtea_key_regs.sv =====
module xtea_key_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xtea_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output xtea_pkg::key_t                key
);

  xtea_pkg::key_t                    key_r;
  logic [xtea_pkg::KEY_IDX_W-1:0]    idx;

  assign idx    = paddr[xtea_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = key_r[idx];
  assign key    = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      key_r[idx] <= pwdata;
    end
  end

endmodule

// ===== hw/rtl/xtea_round_stage.sv =====
module xtea_round_stage #(
  parameter int STAGE  = 0,
  parameter int ROUNDS = xtea_pkg::ROUNDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  xtea_pkg::key_t    key,
  input  logic              valid_in,
  input  xtea_pkg::in_t     item_in,
  output logic              valid_out,
  output xtea_pkg::in_t     item_out
);

  localparam int R = STAGE / 2;
  localparam int H = STAGE % 2;

  localparam logic [63:0] ENC_PROD = 64'(R + H) * 64'(xtea_pkg::DELTA);
  localparam logic [63:0] DEC_PROD = 64'(ROUNDS - R - H) * 64'(xtea_pkg::DELTA);
  localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
  localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];

  // v0 updates index the key by sum[1:0], v1 updates by sum[12:11]
  localparam logic [1:0] ENC_IDX = (H == 0) ? ENC_SUM[1:0]   : ENC_SUM[12:11];
  localparam logic [1:0] DEC_IDX = (H == 0) ? DEC_SUM[12:11] : DEC_SUM[1:0];

  logic          upd_v0;
  logic [31:0]   sum;
  logic [31:0]   key_word;
  logic [31:0]   src;
  logic [31:0]   dst;
  logic [31:0]   term;
  logic [31:0]   dst_nxt;
  logic          valid_r;
  xtea_pkg::in_t item_r;
  xtea_pkg::in_t item_nxt;

  always_comb begin
    // Encrypt updates v0 first in a round, decrypt updates v1 first
    upd_v0   = (H == 0) ^ (item_in.action == xtea_pkg::ACT_DECRYPT);
    sum      = (item_in.action == xtea_pkg::ACT_DECRYPT) ? DEC_SUM : ENC_SUM;
    key_word = (item_in.action == xtea_pkg::ACT_DECRYPT) ? key[DEC_IDX] : key[ENC_IDX];
    src      = upd_v0 ? item_in.block_high : item_in.block_low;
    dst      = upd_v0 ? item_in.block_low  : item_in.block_high;
    term     = xtea_pkg::mix_word(src) ^ (sum + key_word);
    dst_nxt  = (item_in.action == xtea_pkg::ACT_DECRYPT) ? dst - term : dst + term;

    item_nxt = item_in;
    if (upd_v0) begin
      item_nxt.block_low  = dst_nxt;
    end else begin
      item_nxt.block_high = dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
  end

  assign valid_out = valid_r;
  assign item_out  = item_r;

endmodule

// ===== hw/rtl/xtea_block_cipher.sv =====
// XTEA block cipher engine: 64-bit block, 128-bit key in four 32-bit APB
// registers (key_0..key_3 at byte addresses 0x0, 0x4, 0x8, 0xC, reset to
// zero). Each input transfer carries an action (0 encrypt, 1 decrypt) and
// the two block words; each output transfer returns the two result words,
// one result per input, in input order. The datapath is a fully unrolled
// pipeline of 2*ROUNDS register stages, one Feistel half-round per stage,
// so a new block is taken every clock cycle while in_stall is low, and
// each block passes through all stage registers in order. The last
// stage register is the output register. When a result waits with
// out_stall high the whole pipeline holds and in_stall rises in the same
// cycle; nothing is dropped or repeated. Write the key only while the
// pipeline is empty: stages read the key registers directly.
module xtea_block_cipher #(
  parameter int ROUNDS = xtea_pkg::ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  // input transfer channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  xtea_pkg::in_t                 in_data,

  // result transfer channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output xtea_pkg::out_t                out_data,

  // APB-style key register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xtea_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::key_t  key;
  logic            advance;
  logic            valid_pipe [STAGES+1];
  xtea_pkg::in_t   item_pipe  [STAGES+1];

  xtea_key_regs u_key_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // Hold every stage while a finished result is refused downstream
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  assign valid_pipe[0] = in_valid;
  assign item_pipe[0]  = in_data;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    xtea_round_stage #(
      .STAGE  (s),
      .ROUNDS (ROUNDS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .key       (key),
      .valid_in  (valid_pipe[s]),
      .item_in   (item_pipe[s]),
      .valid_out (valid_pipe[s+1]),
      .item_out  (item_pipe[s+1])
    );
  end

  // Last stage register drives the result transfer directly
  assign out_valid         = valid_pipe[STAGES];
  assign out_data.out_low  = item_pipe[STAGES].block_low;
  assign out_data.out_high = item_pipe[STAGES].block_high;

endmodule
